@@ hdl/rmqw_pkg.sv @@
// Package with the types, codes and widths shared by the message queue files.
`timescale 1ns / 1ps

package rmqw_pkg;

    localparam int DATA_W      = 32;
    localparam int TASK_W      = 8;
    localparam int ACT_W       = 3;
    localparam int WAIT_TIME_W = 16;
    localparam int STAT_W      = 3;
    localparam int CAP_W       = 5;

    localparam logic [ACT_W-1:0] ACT_CREATE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEND_WAIT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SEND_POLL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RECV_WAIT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RECV_POLL = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_PARAM   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOEXS   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_TIMEOUT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_WAITING = 3'd4;
    localparam logic [STAT_W-1:0] STAT_DELETED = 3'd5;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd6;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_WAKE  = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]       action;
        logic [TASK_W-1:0]      task_id;
        logic [DATA_W-1:0]      send_data;
        logic [WAIT_TIME_W-1:0] wait_time;
    } request_t;

    typedef struct packed {
        logic              kind;
        logic [TASK_W-1:0] target_task;
        logic [DATA_W-1:0] out_data;
        logic [STAT_W-1:0] status;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [DATA_W-1:0] data;
    } sender_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPLY,
        S_DELETE
    } state_t;

endpackage

@@ hdl/rmqw_ram.sv @@
// Generic single-clock RAM with one write port and one registered, write-first read port.
`timescale 1ns / 1ps

module rmqw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/rtos_message_queue_with_waiters_top.sv @@
// Top level of the message queue with waiting senders and receivers.
`timescale 1ns / 1ps

// A call is taken when start is high and busy is low. It is accepted in the idle state
// and handled in the execute state, in which the ring and both waiter memories already
// present the entries at their current read pointers, so the execute state reads, decides
// and writes back at once. A call that also wakes a waiting task then passes through the
// reply state, and delete goes on to the delete state, where the waiter memories are
// walked one entry a cycle. Each result is on the result port for exactly one cycle while
// result_strobe is high; the receiver cannot stall it, and the last result of a call has
// last set and is always the reply to the caller. There is no clearing pass after reset.
module rtos_message_queue_with_waiters_top #(
    parameter int RING_DEPTH = 16,
    parameter int WAIT_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rmqw_pkg::request_t                request,
    output logic                              result_strobe,
    output rmqw_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [rmqw_pkg::CAP_W-1:0]        cfg_data
);

    localparam int RIDX_W = $clog2(RING_DEPTH);
    localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CW     = (RIDX_W + 1 > rmqw_pkg::CAP_W) ? RIDX_W + 1 : rmqw_pkg::CAP_W;
    localparam int SND_W  = rmqw_pkg::TASK_W + rmqw_pkg::DATA_W;

    rmqw_pkg::state_t state_reg, state_next;

    logic [rmqw_pkg::CAP_W-1:0] capacity_reg;
    logic [rmqw_pkg::CAP_W-1:0] ring_size_reg, ring_size_next;
    logic                       exists_reg, exists_next;
    logic [RIDX_W-1:0]          write_index_reg, write_index_next;
    logic [RIDX_W-1:0]          read_index_reg, read_index_next;
    logic [WIDX_W-1:0]          snd_head_reg, snd_head_next;
    logic [CNT_W-1:0]           snd_count_reg, snd_count_next;
    logic [WIDX_W-1:0]          rcv_head_reg, rcv_head_next;
    logic [CNT_W-1:0]           rcv_count_reg, rcv_count_next;

    rmqw_pkg::request_t         cmd_reg, cmd_next;
    logic [rmqw_pkg::DATA_W-1:0] reply_data_reg, reply_data_next;
    rmqw_pkg::result_t          result_reg, result_next;
    logic                       strobe_reg, strobe_next;

    logic                        ring_we;
    logic [rmqw_pkg::DATA_W-1:0] ring_wdata;
    logic [rmqw_pkg::DATA_W-1:0] ring_rdata;
    logic                        snd_we;
    rmqw_pkg::sender_entry_t     snd_wdata;
    logic [SND_W-1:0]            snd_rdata_raw;
    rmqw_pkg::sender_entry_t     snd_rdata;
    logic                        rcv_we;
    logic [rmqw_pkg::TASK_W-1:0] rcv_rdata;

    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     cap_ext;
    logic [CW-1:0]     cap_sat;
    logic [CW-1:0]     wr_inc;
    logic [CW-1:0]     rd_inc;
    logic [RIDX_W-1:0] wr_wrap;
    logic [RIDX_W-1:0] rd_wrap;
    logic              can_put;
    logic              can_get;
    logic [SUM_W-1:0]  snd_sum;
    logic [SUM_W-1:0]  rcv_sum;
    logic [WIDX_W-1:0] snd_slot;
    logic [WIDX_W-1:0] rcv_slot;
    logic [WIDX_W-1:0] snd_head_inc;
    logic [WIDX_W-1:0] rcv_head_inc;
    logic              accept;
    logic              is_send;
    logic              is_recv;
    logic              is_wait;
    logic              valid_call;
    logic              go_delete;
    logic              two_results;
    logic              snd_any;
    logic              rcv_any;

    assign accept  = start && !busy;
    assign busy    = (state_reg != rmqw_pkg::S_IDLE);
    assign result  = result_reg;
    assign result_strobe = strobe_reg;
    assign snd_rdata = rmqw_pkg::sender_entry_t'(snd_rdata_raw);

    // Ring and waiter-list index arithmetic.
    always_comb
    begin
        size_ext = CW'(ring_size_reg);
        cap_ext  = CW'(capacity_reg);
        cap_sat  = (cap_ext > CW'(RING_DEPTH)) ? CW'(RING_DEPTH) : cap_ext;
        wr_inc   = CW'(write_index_reg) + CW'(1);
        rd_inc   = CW'(read_index_reg) + CW'(1);
        wr_wrap  = (wr_inc >= size_ext) ? '0 : wr_inc[RIDX_W-1:0];
        rd_wrap  = (rd_inc >= size_ext) ? '0 : rd_inc[RIDX_W-1:0];
        can_put  = (size_ext >= CW'(2)) && (wr_wrap != read_index_reg);
        can_get  = (size_ext >= CW'(2)) && (read_index_reg != write_index_reg);
        snd_sum  = SUM_W'(snd_head_reg) + SUM_W'(snd_count_reg);
        rcv_sum  = SUM_W'(rcv_head_reg) + SUM_W'(rcv_count_reg);
        snd_slot = (snd_sum >= SUM_W'(WAIT_DEPTH)) ?
                   WIDX_W'(snd_sum - SUM_W'(WAIT_DEPTH)) : WIDX_W'(snd_sum);
        rcv_slot = (rcv_sum >= SUM_W'(WAIT_DEPTH)) ?
                   WIDX_W'(rcv_sum - SUM_W'(WAIT_DEPTH)) : WIDX_W'(rcv_sum);
        snd_head_inc = (snd_head_reg == WIDX_W'(WAIT_DEPTH - 1)) ?
                       '0 : snd_head_reg + WIDX_W'(1);
        rcv_head_inc = (rcv_head_reg == WIDX_W'(WAIT_DEPTH - 1)) ?
                       '0 : rcv_head_reg + WIDX_W'(1);
        snd_any  = (snd_count_reg != '0);
        rcv_any  = (rcv_count_reg != '0);
    end

    // Call classification.
    always_comb
    begin
        is_send = (cmd_reg.action == rmqw_pkg::ACT_SEND_WAIT) ||
                  (cmd_reg.action == rmqw_pkg::ACT_SEND_POLL);
        is_recv = (cmd_reg.action == rmqw_pkg::ACT_RECV_WAIT) ||
                  (cmd_reg.action == rmqw_pkg::ACT_RECV_POLL);
        is_wait = (cmd_reg.action == rmqw_pkg::ACT_SEND_WAIT) ||
                  (cmd_reg.action == rmqw_pkg::ACT_RECV_WAIT);
        valid_call = exists_reg && (cmd_reg.action != rmqw_pkg::ACT_CREATE) &&
                     (cmd_reg.action <= rmqw_pkg::ACT_RECV_POLL) &&
                     !(is_wait && (cmd_reg.wait_time == '0));
        go_delete   = valid_call && (cmd_reg.action == rmqw_pkg::ACT_DELETE);
        two_results = valid_call && ((is_send && rcv_any) || (is_recv && snd_any));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmqw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = rmqw_pkg::S_EXEC;
                end
            end
            rmqw_pkg::S_EXEC:
            begin
                if (go_delete)
                begin
                    state_next = rmqw_pkg::S_DELETE;
                end
                else if (two_results)
                begin
                    state_next = rmqw_pkg::S_REPLY;
                end
                else
                begin
                    state_next = rmqw_pkg::S_IDLE;
                end
            end
            rmqw_pkg::S_REPLY:
            begin
                state_next = rmqw_pkg::S_IDLE;
            end
            rmqw_pkg::S_DELETE:
            begin
                if (!snd_any && !rcv_any)
                begin
                    state_next = rmqw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rmqw_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory writes and results.
    always_comb
    begin
        cmd_next         = cmd_reg;
        reply_data_next  = reply_data_reg;
        ring_size_next   = ring_size_reg;
        exists_next      = exists_reg;
        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        snd_head_next    = snd_head_reg;
        snd_count_next   = snd_count_reg;
        rcv_head_next    = rcv_head_reg;
        rcv_count_next   = rcv_count_reg;
        ring_we          = 1'b0;
        ring_wdata       = cmd_reg.send_data;
        snd_we           = 1'b0;
        snd_wdata.task_id = cmd_reg.task_id;
        snd_wdata.data   = cmd_reg.send_data;
        rcv_we           = 1'b0;
        strobe_next      = 1'b0;
        result_next.kind        = rmqw_pkg::KIND_REPLY;
        result_next.target_task = cmd_reg.task_id;
        result_next.out_data    = '0;
        result_next.status      = rmqw_pkg::STAT_OK;
        result_next.last        = 1'b1;

        unique case (state_reg)
            rmqw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = request;
                end
            end
            rmqw_pkg::S_EXEC:
            begin
                strobe_next = 1'b1;
                priority if (cmd_reg.action > rmqw_pkg::ACT_RECV_POLL)
                begin
                    result_next.status = rmqw_pkg::STAT_PARAM;
                end
                else if (cmd_reg.action == rmqw_pkg::ACT_CREATE)
                begin
                    if (exists_reg)
                    begin
                        result_next.status = rmqw_pkg::STAT_PARAM;
                    end
                    else
                    begin
                        ring_size_next   = cap_sat[rmqw_pkg::CAP_W-1:0];
                        write_index_next = '0;
                        read_index_next  = '0;
                        snd_head_next    = '0;
                        snd_count_next   = '0;
                        rcv_head_next    = '0;
                        rcv_count_next   = '0;
                        exists_next      = 1'b1;
                    end
                end
                else if (is_wait && (cmd_reg.wait_time == '0))
                begin
                    result_next.status = rmqw_pkg::STAT_PARAM;
                end
                else if (!exists_reg)
                begin
                    result_next.status = rmqw_pkg::STAT_NOEXS;
                end
                else if (cmd_reg.action == rmqw_pkg::ACT_DELETE)
                begin
                    strobe_next = 1'b0;
                end
                else if (is_send)
                begin
                    priority if (rcv_any)
                    begin
                        result_next.kind        = rmqw_pkg::KIND_WAKE;
                        result_next.target_task = rcv_rdata;
                        result_next.out_data    = cmd_reg.send_data;
                        result_next.last        = 1'b0;
                        reply_data_next         = '0;
                        rcv_head_next           = rcv_head_inc;
                        rcv_count_next          = rcv_count_reg - CNT_W'(1);
                    end
                    else if (can_put)
                    begin
                        ring_we          = 1'b1;
                        write_index_next = wr_wrap;
                    end
                    else if (cmd_reg.action == rmqw_pkg::ACT_SEND_POLL)
                    begin
                        result_next.status = rmqw_pkg::STAT_TIMEOUT;
                    end
                    else if (snd_count_reg == CNT_W'(WAIT_DEPTH))
                    begin
                        result_next.status = rmqw_pkg::STAT_FULL;
                    end
                    else
                    begin
                        snd_we             = 1'b1;
                        snd_count_next     = snd_count_reg + CNT_W'(1);
                        result_next.status = rmqw_pkg::STAT_WAITING;
                    end
                end
                else
                begin
                    priority if (can_get)
                    begin
                        read_index_next = rd_wrap;
                        if (snd_any)
                        begin
                            ring_we                 = 1'b1;
                            ring_wdata              = snd_rdata.data;
                            write_index_next        = wr_wrap;
                            snd_head_next           = snd_head_inc;
                            snd_count_next          = snd_count_reg - CNT_W'(1);
                            result_next.kind        = rmqw_pkg::KIND_WAKE;
                            result_next.target_task = snd_rdata.task_id;
                            result_next.last        = 1'b0;
                            reply_data_next         = ring_rdata;
                        end
                        else
                        begin
                            result_next.out_data = ring_rdata;
                        end
                    end
                    else if (snd_any)
                    begin
                        snd_head_next           = snd_head_inc;
                        snd_count_next          = snd_count_reg - CNT_W'(1);
                        result_next.kind        = rmqw_pkg::KIND_WAKE;
                        result_next.target_task = snd_rdata.task_id;
                        result_next.last        = 1'b0;
                        reply_data_next         = snd_rdata.data;
                    end
                    else if (cmd_reg.action == rmqw_pkg::ACT_RECV_POLL)
                    begin
                        result_next.status = rmqw_pkg::STAT_TIMEOUT;
                    end
                    else if (rcv_count_reg == CNT_W'(WAIT_DEPTH))
                    begin
                        result_next.status = rmqw_pkg::STAT_FULL;
                    end
                    else
                    begin
                        rcv_we             = 1'b1;
                        rcv_count_next     = rcv_count_reg + CNT_W'(1);
                        result_next.status = rmqw_pkg::STAT_WAITING;
                    end
                end
            end
            rmqw_pkg::S_REPLY:
            begin
                strobe_next          = 1'b1;
                result_next.out_data = reply_data_reg;
            end
            rmqw_pkg::S_DELETE:
            begin
                strobe_next = 1'b1;
                priority if (snd_any)
                begin
                    result_next.kind        = rmqw_pkg::KIND_WAKE;
                    result_next.target_task = snd_rdata.task_id;
                    result_next.status      = rmqw_pkg::STAT_DELETED;
                    result_next.last        = 1'b0;
                    snd_head_next           = snd_head_inc;
                    snd_count_next          = snd_count_reg - CNT_W'(1);
                end
                else if (rcv_any)
                begin
                    result_next.kind        = rmqw_pkg::KIND_WAKE;
                    result_next.target_task = rcv_rdata;
                    result_next.status      = rmqw_pkg::STAT_DELETED;
                    result_next.last        = 1'b0;
                    rcv_head_next           = rcv_head_inc;
                    rcv_count_next          = rcv_count_reg - CNT_W'(1);
                end
                else
                begin
                    exists_next = 1'b0;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rmqw_pkg::S_IDLE;
            capacity_reg    <= rmqw_pkg::CAP_W'(16);
            ring_size_reg   <= '0;
            exists_reg      <= 1'b0;
            write_index_reg <= '0;
            read_index_reg  <= '0;
            snd_head_reg    <= '0;
            snd_count_reg   <= '0;
            rcv_head_reg    <= '0;
            rcv_count_reg   <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            ring_size_reg   <= ring_size_next;
            exists_reg      <= exists_next;
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            snd_head_reg    <= snd_head_next;
            snd_count_reg   <= snd_count_next;
            rcv_head_reg    <= rcv_head_next;
            rcv_count_reg   <= rcv_count_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        reply_data_reg <= reply_data_next;
        result_reg     <= result_next;
    end

    // The read ports follow the next pointers, so each memory presents the entry at the
    // current pointer in every cycle.
    rmqw_ram #(
        .WIDTH (rmqw_pkg::DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (write_index_reg),
        .wdata (ring_wdata),
        .raddr (read_index_next),
        .rdata (ring_rdata)
    );

    rmqw_ram #(
        .WIDTH (SND_W),
        .DEPTH (WAIT_DEPTH)
    ) u_sender_ram (
        .clk   (clk),
        .we    (snd_we),
        .waddr (snd_slot),
        .wdata (SND_W'(snd_wdata)),
        .raddr (snd_head_next),
        .rdata (snd_rdata_raw)
    );

    rmqw_ram #(
        .WIDTH (rmqw_pkg::TASK_W),
        .DEPTH (WAIT_DEPTH)
    ) u_receiver_ram (
        .clk   (clk),
        .we    (rcv_we),
        .waddr (rcv_slot),
        .wdata (cmd_reg.task_id),
        .raddr (rcv_head_next),
        .rdata (rcv_rdata)
    );

`ifndef ASSERT_OFF
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> !busy)
        else $error("Final result shown while the block is still busy.");

    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |=> result_strobe)
        else $error("A non-final result was not followed by another result.");

    a_snd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        snd_count_reg <= CNT_W'(WAIT_DEPTH))
        else $error("Sender list count exceeds its depth.");

    a_ring_index: assert property (@(posedge clk) disable iff (!rst_n)
        (exists_reg && (size_ext >= CW'(2))) |->
        ((CW'(read_index_reg) < size_ext) && (CW'(write_index_reg) < size_ext)))
        else $error("Ring index outside the ring size in use.");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the message queue with waiting senders and receivers.
`timescale 1ns / 1ps

module testbench;

    localparam int RING_DEPTH = 16;
    localparam int WAIT_DEPTH = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [rmqw_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [rmqw_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        STEP_CALL,
        STEP_SET_CAP,
        STEP_DRAIN
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t                   what;
        rmqw_pkg::request_t           req;
        logic [rmqw_pkg::CAP_W-1:0]   cap;
    } plan_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rmqw_pkg::request_t request = '0;
    logic result_strobe;
    rmqw_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [rmqw_pkg::CAP_W-1:0] cfg_data = '0;

    plan_step_t call_plan[$];
    rmqw_pkg::result_t outcomes_due[$];
    int mismatch_count = 0;
    int gap_left = 0;
    int burst_left = 0;
    int cycle_count = 0;

    logic [rmqw_pkg::CAP_W-1:0] cap_reg = 5'd16;
    logic [rmqw_pkg::DATA_W-1:0] ring_words [RING_DEPTH];
    int ring_len = 0;
    int wr_pos = 0;
    int rd_pos = 0;
    bit q_live = 1'b0;
    logic [rmqw_pkg::TASK_W-1:0] snd_task [WAIT_DEPTH];
    logic [rmqw_pkg::DATA_W-1:0] snd_word [WAIT_DEPTH];
    int snd_head = 0;
    int snd_cnt = 0;
    logic [rmqw_pkg::TASK_W-1:0] rcv_task [WAIT_DEPTH];
    int rcv_head = 0;
    int rcv_cnt = 0;

    rtos_message_queue_with_waiters_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void owe(logic kind, logic [rmqw_pkg::TASK_W-1:0] tid,
                                logic [rmqw_pkg::DATA_W-1:0] word,
                                logic [rmqw_pkg::STAT_W-1:0] stat, logic fin);
        rmqw_pkg::result_t r;
        r.kind        = kind;
        r.target_task = tid;
        r.out_data    = word;
        r.status      = stat;
        r.last        = fin;
        outcomes_due.push_back(r);
    endfunction

    function automatic bit ring_push(logic [rmqw_pkg::DATA_W-1:0] word);
        int nxt;
        if (ring_len < 2)
            return 1'b0;
        nxt = wr_pos + 1;
        if (nxt >= ring_len)
            nxt = 0;
        if (nxt == rd_pos)
            return 1'b0;
        ring_words[wr_pos] = word;
        wr_pos = nxt;
        return 1'b1;
    endfunction

    function automatic void take_sender(output logic [rmqw_pkg::TASK_W-1:0] tid,
                                        output logic [rmqw_pkg::DATA_W-1:0] word);
        tid = snd_task[snd_head];
        word = snd_word[snd_head];
        snd_head = (snd_head + 1) % WAIT_DEPTH;
        snd_cnt--;
    endfunction

    function automatic logic [rmqw_pkg::TASK_W-1:0] take_receiver();
        logic [rmqw_pkg::TASK_W-1:0] tid;
        tid = rcv_task[rcv_head];
        rcv_head = (rcv_head + 1) % WAIT_DEPTH;
        rcv_cnt--;
        return tid;
    endfunction

    function automatic void serve_call(rmqw_pkg::request_t req);
        logic [rmqw_pkg::TASK_W-1:0] tid;
        logic [rmqw_pkg::TASK_W-1:0] woken;
        logic [rmqw_pkg::DATA_W-1:0] word;
        logic [rmqw_pkg::DATA_W-1:0] spare;
        int slot;
        tid = req.task_id;
        if (req.action > rmqw_pkg::ACT_RECV_POLL)
        begin
            owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_PARAM, 1'b1);
        end
        else if (req.action == rmqw_pkg::ACT_CREATE)
        begin
            if (q_live)
            begin
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_PARAM, 1'b1);
            end
            else
            begin
                ring_len = (int'(cap_reg) > RING_DEPTH) ? RING_DEPTH : int'(cap_reg);
                wr_pos = 0;
                rd_pos = 0;
                snd_head = 0;
                snd_cnt = 0;
                rcv_head = 0;
                rcv_cnt = 0;
                q_live = 1'b1;
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_OK, 1'b1);
            end
        end
        else if ((req.action == rmqw_pkg::ACT_SEND_WAIT ||
                  req.action == rmqw_pkg::ACT_RECV_WAIT) && req.wait_time == '0)
        begin
            owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_PARAM, 1'b1);
        end
        else if (!q_live)
        begin
            owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_NOEXS, 1'b1);
        end
        else if (req.action == rmqw_pkg::ACT_DELETE)
        begin
            while (snd_cnt > 0)
            begin
                take_sender(woken, spare);
                owe(rmqw_pkg::KIND_WAKE, woken, '0, rmqw_pkg::STAT_DELETED, 1'b0);
            end
            while (rcv_cnt > 0)
            begin
                woken = take_receiver();
                owe(rmqw_pkg::KIND_WAKE, woken, '0, rmqw_pkg::STAT_DELETED, 1'b0);
            end
            q_live = 1'b0;
            owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_OK, 1'b1);
        end
        else if (req.action == rmqw_pkg::ACT_SEND_WAIT ||
                 req.action == rmqw_pkg::ACT_SEND_POLL)
        begin
            if (rcv_cnt > 0)
            begin
                woken = take_receiver();
                owe(rmqw_pkg::KIND_WAKE, woken, req.send_data, rmqw_pkg::STAT_OK, 1'b0);
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_OK, 1'b1);
            end
            else if (ring_push(req.send_data))
            begin
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_OK, 1'b1);
            end
            else if (req.action == rmqw_pkg::ACT_SEND_POLL)
            begin
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_TIMEOUT, 1'b1);
            end
            else if (snd_cnt >= WAIT_DEPTH)
            begin
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_FULL, 1'b1);
            end
            else
            begin
                slot = (snd_head + snd_cnt) % WAIT_DEPTH;
                snd_task[slot] = tid;
                snd_word[slot] = req.send_data;
                snd_cnt++;
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_WAITING, 1'b1);
            end
        end
        else
        begin
            if (ring_len >= 2 && rd_pos != wr_pos)
            begin
                word = ring_words[rd_pos];
                rd_pos++;
                if (rd_pos >= ring_len)
                    rd_pos = 0;
                if (snd_cnt > 0)
                begin
                    take_sender(woken, spare);
                    void'(ring_push(spare));
                    owe(rmqw_pkg::KIND_WAKE, woken, '0, rmqw_pkg::STAT_OK, 1'b0);
                end
                owe(rmqw_pkg::KIND_REPLY, tid, word, rmqw_pkg::STAT_OK, 1'b1);
            end
            else if (snd_cnt > 0)
            begin
                take_sender(woken, word);
                owe(rmqw_pkg::KIND_WAKE, woken, '0, rmqw_pkg::STAT_OK, 1'b0);
                owe(rmqw_pkg::KIND_REPLY, tid, word, rmqw_pkg::STAT_OK, 1'b1);
            end
            else if (req.action == rmqw_pkg::ACT_RECV_POLL)
            begin
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_TIMEOUT, 1'b1);
            end
            else if (rcv_cnt >= WAIT_DEPTH)
            begin
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_FULL, 1'b1);
            end
            else
            begin
                rcv_task[(rcv_head + rcv_cnt) % WAIT_DEPTH] = tid;
                rcv_cnt++;
                owe(rmqw_pkg::KIND_REPLY, tid, '0, rmqw_pkg::STAT_WAITING, 1'b1);
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void plan_call(logic [rmqw_pkg::ACT_W-1:0] act,
                                      logic [rmqw_pkg::TASK_W-1:0] tid,
                                      logic [rmqw_pkg::DATA_W-1:0] word,
                                      logic [rmqw_pkg::WAIT_TIME_W-1:0] wt);
        plan_step_t s;
        s = '0;
        s.what = STEP_CALL;
        s.req.action = act;
        s.req.task_id = tid;
        s.req.send_data = word;
        s.req.wait_time = wt;
        call_plan.push_back(s);
    endfunction

    function automatic void plan_cap(logic [rmqw_pkg::CAP_W-1:0] value);
        plan_step_t s;
        s = '0;
        s.what = STEP_SET_CAP;
        s.cap = value;
        call_plan.push_back(s);
    endfunction

    always @(posedge clk)
    begin : drive_calls
        plan_step_t step;
        logic go;
        logic we;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
        end
        else
        begin
            go = start;
            we = 1'b0;
            if (start && !busy)
            begin
                serve_call(request);
                go = 1'b0;
                gap_left = pick_gap();
            end
            if (!go)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (call_plan.size() > 0)
                begin
                    step = call_plan[0];
                    if (step.what == STEP_CALL)
                    begin
                        void'(call_plan.pop_front());
                        request <= step.req;
                        go = 1'b1;
                    end
                    else if (outcomes_due.size() == 0 && !busy && !start && !cfg_we)
                    begin
                        void'(call_plan.pop_front());
                        if (step.what == STEP_SET_CAP)
                        begin
                            we = 1'b1;
                            cfg_data <= step.cap;
                            cap_reg = step.cap;
                        end
                    end
                end
            end
            start <= go;
            cfg_we <= we;
        end
    end

    always @(posedge clk)
    begin : check_results
        rmqw_pkg::result_t want;
        if (rst_n && result_strobe)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("unexpected result for task %0d", result.target_task);
                mismatch_count++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (result.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    mismatch_count++;
                end
                if (result.target_task !== want.target_task)
                begin
                    $error("target_task: expected %0d, got %0d", want.target_task,
                           result.target_task);
                    mismatch_count++;
                end
                if (result.out_data !== want.out_data)
                begin
                    $error("out_data: expected %08h, got %08h", want.out_data, result.out_data);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int random_made;
        int phase;
        int n;
        int bias;
        int hold_at;
        int i;
        logic [rmqw_pkg::CAP_W-1:0] cap;
        logic [rmqw_pkg::ACT_W-1:0] act;
        logic [rmqw_pkg::WAIT_TIME_W-1:0] wt;
        plan_step_t hold;

        // Calls on a missing queue, bad parameters and the basic transfer paths.
        plan_call(rmqw_pkg::ACT_SEND_POLL, 8'd1, 32'h0000_0001, 16'd0);
        plan_call(rmqw_pkg::ACT_SEND_WAIT, 8'd2, 32'h0000_0002, 16'd0);
        plan_call(rmqw_pkg::ACT_RECV_WAIT, 8'd3, '0, 16'd0);
        plan_call(ACT_SPARE_LO, 8'd4, '0, 16'd9);
        plan_call(ACT_SPARE_HI, 8'd5, '0, 16'd9);
        plan_call(rmqw_pkg::ACT_DELETE, 8'd6, '0, 16'd5);
        plan_call(rmqw_pkg::ACT_CREATE, 8'd7, '0, 16'd0);
        plan_call(rmqw_pkg::ACT_CREATE, 8'd8, '0, 16'd3);
        plan_call(rmqw_pkg::ACT_SEND_POLL, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        plan_call(rmqw_pkg::ACT_SEND_WAIT, 8'h00, 32'h0000_0000, 16'hFFFF);
        plan_call(rmqw_pkg::ACT_RECV_POLL, 8'h10, '0, 16'd0);
        plan_call(rmqw_pkg::ACT_RECV_WAIT, 8'h11, '0, 16'd1);
        plan_call(rmqw_pkg::ACT_RECV_POLL, 8'h12, '0, 16'd0);
        plan_call(rmqw_pkg::ACT_RECV_WAIT, 8'h13, '0, 16'd1);
        plan_call(rmqw_pkg::ACT_RECV_WAIT, 8'h14, '0, 16'd2);
        plan_call(rmqw_pkg::ACT_SEND_POLL, 8'h15, 32'hA5A5_5A5A, 16'd0);
        plan_call(rmqw_pkg::ACT_DELETE, 8'h16, '0, 16'd0);
        plan_cap(5'd1);
        plan_call(rmqw_pkg::ACT_CREATE, 8'h20, '0, 16'd0);
        plan_call(rmqw_pkg::ACT_SEND_POLL, 8'h21, 32'h5A5A_A5A5, 16'd0);
        plan_call(rmqw_pkg::ACT_SEND_WAIT, 8'h22, 32'h1234_5678, 16'd7);
        plan_call(rmqw_pkg::ACT_RECV_POLL, 8'h23, '0, 16'd0);
        plan_call(rmqw_pkg::ACT_RECV_POLL, 8'h24, '0, 16'd0);
        plan_call(rmqw_pkg::ACT_DELETE, 8'h25, '0, 16'd1);

        random_made = 0;
        phase = 0;
        while (random_made < 456)
        begin
            case (phase)
                0: cap = 5'd0;
                1: cap = 5'd2;
                2: cap = 5'd16;
                3: cap = 5'd31;
                4: cap = 5'd3;
                default: cap = 5'($urandom_range(0, 31));
            endcase
            plan_cap(cap);
            plan_call(rmqw_pkg::ACT_CREATE, 8'($urandom), $urandom, 16'($urandom));
            n = $urandom_range(20, 60);
            bias = $urandom_range(15, 85);
            hold_at = $urandom_range(0, n - 1);
            for (i = 0; i < n; i++)
            begin
                if (i == hold_at)
                begin
                    hold = '0;
                    hold.what = STEP_DRAIN;
                    call_plan.push_back(hold);
                end
                if ($urandom_range(0, 99) < 7)
                begin
                    act = 3'($urandom_range(0, 7));
                    wt = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom);
                end
                else
                begin
                    if ($urandom_range(0, 99) < bias)
                        act = ($urandom_range(0, 2) == 0) ? rmqw_pkg::ACT_SEND_POLL :
                                                            rmqw_pkg::ACT_SEND_WAIT;
                    else
                        act = ($urandom_range(0, 2) == 0) ? rmqw_pkg::ACT_RECV_POLL :
                                                            rmqw_pkg::ACT_RECV_WAIT;
                    wt = 16'($urandom_range(1, 65535));
                end
                plan_call(act, 8'($urandom), $urandom, wt);
            end
            plan_call(rmqw_pkg::ACT_DELETE, 8'($urandom), $urandom,
                      16'($urandom_range(1, 65535)));
            random_made += n + 2;
            phase++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (call_plan.size() != 0 || start || busy || outcomes_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/rmqw_pkg.sv
hdl/rmqw_ram.sv
hdl/rtos_message_queue_with_waiters_top.sv
test/testbench.sv
